[hdl/jps_pkg.sv]
// Package for the Jacobi 5-point stencil sweep block.
// Holds the grid limits, data widths, register codes and the result record.
// Used by the top level and the checker; depends on nothing.
package jps_pkg;

  localparam int MAX_SIDE   = 256;
  localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
  localparam int COUNT_W    = $clog2(MAX_SIDE * MAX_SIDE + 1);
  localparam int LB_DEPTH   = MAX_SIDE;
  localparam int LB_AW      = $clog2(LB_DEPTH);
  localparam int FD_DEPTH   = MAX_SIDE + 1;
  localparam int FD_AW      = $clog2(FD_DEPTH);
  localparam int DATA_W     = 32;
  localparam int DIFF_W     = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [SIDE_W-1:0]  MIN_SIDE_VAL   = SIDE_W'(3);
  localparam logic [SIDE_W-1:0]  MAX_SIDE_VAL   = SIDE_W'(MAX_SIDE);
  localparam logic [8:0]         GRID_RESET     = 9'd201;
  localparam logic [31:0]        HSQ_RESET      = 32'd107374;
  localparam logic [DIFF_W-1:0]  TOL_RESET      = DIFF_W'(5);
  localparam logic [DIFF_W-1:0]  DIFF_MAX       = {DIFF_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_SIZE = 2'd0,
    CFG_H_SQUARED = 2'd1,
    CFG_TOLERANCE = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic push;
    logic emit;
    logic bnd;
    logic last;
  } ctl_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] new_value;
    logic [DIFF_W-1:0]        max_diff;
    logic                     converged;
    logic                     last;
  } result_t;

endpackage

[hdl/jps_ram.sv]
// Generic single-port RAM with a registered, read-first read port.
// Used for the line buffers and the source delay line; depends on nothing.
module jps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    rdata <= mem[addr];
    if (we) begin
      mem[addr] <= wdata;
    end
  end

endmodule

[hdl/jacobi_poisson_stencil_sweep_top.sv]
// Top level of the Jacobi 5-point Poisson stencil sweep block.
// Depends on jps_pkg and on jps_ram for the two line buffers and the source delay.
//
// The block accepts one grid point per clock in row-major order while in_stall is
// low and returns the updated value of each point one row plus one point later;
// after the last point, S+1 drain requests flush the remaining results. Sustained
// rate is one request per cycle while in_stall is low. A result passes through
// registered pipeline stages before it enters the output queue; they cover the read
// of the two cascaded line buffers, the window alignment, the multiplier stage and
// the rounding and difference stages. Up to sixteen released results may be
// outstanding; beyond that in_stall rises until results are taken.
// No clearing pass is needed after reset.
module jacobi_poisson_stencil_sweep_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             func,
  input  logic signed [jps_pkg::DATA_W-1:0] u_value,
  input  logic signed [jps_pkg::DATA_W-1:0] f_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [jps_pkg::DATA_W-1:0] new_value,
  output logic [jps_pkg::DIFF_W-1:0]        max_diff,
  output logic                             converged,
  output logic                             last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [jps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                      cfg_data
);
  import jps_pkg::*;

  logic [8:0]         grid_size;
  logic [31:0]        h_squared;
  logic [DIFF_W-1:0]  tolerance;

  logic [SIDE_W-1:0]  side;
  logic [COUNT_W-1:0] total;
  logic [COUNT_W-1:0] points_in;
  logic [COUNT_W-1:0] emitted_count;
  logic [SIDE_W-1:0]  row_pos;
  logic [SIDE_W-1:0]  col_pos;
  logic [LB_AW-1:0]   lb_ptr;
  logic [FD_AW-1:0]   fd_ptr;

  logic [SIDE_W-1:0]  clamp_side;
  logic [SIDE_W-1:0]  eff_side;
  logic [COUNT_W-1:0] eff_total;
  logic               accept;
  logic               first;
  logic               take;
  logic               drain_ok;
  logic               push;
  logic               emit;
  logic               is_last;
  logic               bnd;
  logic [COUNT_W:0]   pin_plus1;

  ctl_t               s1_ctl;
  logic signed [DATA_W-1:0] s1_u;
  logic [LB_AW-1:0]   s1_ptr;
  logic [DATA_W-1:0]  lb1_q;
  logic [DATA_W-1:0]  lb2_q;
  logic [DATA_W-1:0]  fd_q;

  ctl_t               s2_ctl;
  logic signed [DATA_W-1:0] s2_b;
  logic signed [DATA_W-1:0] s2_m;
  logic signed [DATA_W-1:0] s2_f;

  logic signed [DATA_W-1:0] win_r;
  logic signed [DATA_W-1:0] win_c;
  logic signed [DATA_W-1:0] win_up;
  logic signed [DATA_W-1:0] win_dn;

  ctl_t               s3_ctl;
  logic signed [DATA_W-1:0] s3_up;
  logic signed [DATA_W-1:0] s3_dn;
  logic signed [DATA_W-1:0] s3_lf;
  logic signed [DATA_W-1:0] s3_rt;
  logic signed [DATA_W-1:0] s3_ct;
  logic signed [DATA_W-1:0] s3_f;

  ctl_t               s4_ctl;
  logic signed [33:0] s4_sum;
  logic signed [63:0] s4_prod;
  logic signed [DATA_W-1:0] s4_ct;
  logic signed [32:0] hs_ext;

  logic signed [41:0] v_rnd;
  logic signed [41:0] r_sh;
  logic signed [DATA_W-1:0] nv_sat;

  ctl_t               s5_ctl;
  logic signed [DATA_W-1:0] s5_nv;
  logic signed [DATA_W-1:0] s5_old;

  logic signed [32:0] d_raw;
  logic [32:0]        d_abs;
  logic [DIFF_W-1:0]  d_sat;

  ctl_t               s6_ctl;
  logic signed [DATA_W-1:0] s6_nv;
  logic [DIFF_W-1:0]  s6_diff;

  logic [DIFF_W-1:0]  running_max;
  logic [DIFF_W-1:0]  max_next;
  result_t            res_in;

  result_t            fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0] fifo_wr;
  logic [FIFO_AW-1:0] fifo_rd;
  logic [FIFO_AW:0]   fifo_fill;
  logic [FIFO_AW:0]   credit;
  logic               pop;
  logic               fifo_push;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= GRID_RESET;
      h_squared <= HSQ_RESET;
      tolerance <= TOL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_GRID_SIZE: grid_size <= cfg_data[8:0];
        CFG_H_SQUARED: h_squared <= cfg_data;
        CFG_TOLERANCE: tolerance <= cfg_data[DIFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (grid_size < 9'(MIN_SIDE_VAL)) begin
      clamp_side = MIN_SIDE_VAL;
    end else if (grid_size > 9'(MAX_SIDE_VAL)) begin
      clamp_side = MAX_SIDE_VAL;
    end else begin
      clamp_side = SIDE_W'(grid_size);
    end
  end

  assign accept    = in_valid && !in_stall;
  assign first     = (points_in == '0);
  assign eff_side  = first ? clamp_side : side;
  assign eff_total = first ? COUNT_W'(clamp_side * clamp_side) : total;
  assign take      = !func && (points_in < eff_total);
  assign drain_ok  = func && !first && (points_in == total) && (emitted_count < total);
  assign push      = accept && (take || drain_ok);
  assign pin_plus1 = (COUNT_W+1)'(points_in) + (COUNT_W+1)'(1);
  assign emit      = push && (drain_ok || (pin_plus1 >= (COUNT_W+1)'(eff_side) + (COUNT_W+1)'(2)));
  assign is_last   = (emitted_count + COUNT_W'(1)) == eff_total;
  assign bnd       = (row_pos == '0) || (row_pos == eff_side - SIDE_W'(1)) ||
                     (col_pos == '0) || (col_pos == eff_side - SIDE_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      side          <= MIN_SIDE_VAL;
      total         <= '0;
      points_in     <= '0;
      emitted_count <= '0;
      row_pos       <= '0;
      col_pos       <= '0;
      lb_ptr        <= '0;
      fd_ptr        <= '0;
    end else if (push) begin
      if (first) begin
        side  <= clamp_side;
        total <= eff_total;
      end
      if (take) begin
        points_in <= points_in + COUNT_W'(1);
      end
      if (SIDE_W'(lb_ptr) == eff_side - SIDE_W'(1)) begin
        lb_ptr <= '0;
      end else begin
        lb_ptr <= lb_ptr + LB_AW'(1);
      end
      if (SIDE_W'(fd_ptr) == eff_side) begin
        fd_ptr <= '0;
      end else begin
        fd_ptr <= fd_ptr + FD_AW'(1);
      end
      if (emit) begin
        emitted_count <= emitted_count + COUNT_W'(1);
        if (col_pos + SIDE_W'(1) >= eff_side) begin
          col_pos <= '0;
          row_pos <= row_pos + SIDE_W'(1);
        end else begin
          col_pos <= col_pos + SIDE_W'(1);
        end
        if (is_last) begin
          points_in     <= '0;
          emitted_count <= '0;
          row_pos       <= '0;
          col_pos       <= '0;
          lb_ptr        <= '0;
          fd_ptr        <= '0;
        end
      end
    end
  end

  jps_ram #(.WIDTH(DATA_W), .DEPTH(LB_DEPTH)) u_lb1 (
    .clk   (clk),
    .we    (push),
    .addr  (lb_ptr),
    .wdata (u_value),
    .rdata (lb1_q)
  );

  jps_ram #(.WIDTH(DATA_W), .DEPTH(FD_DEPTH)) u_fd (
    .clk   (clk),
    .we    (push),
    .addr  (fd_ptr),
    .wdata (f_value),
    .rdata (fd_q)
  );

  jps_ram #(.WIDTH(DATA_W), .DEPTH(LB_DEPTH)) u_lb2 (
    .clk   (clk),
    .we    (s1_ctl.push),
    .addr  (s1_ptr),
    .wdata (lb1_q),
    .rdata (lb2_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
      s2_ctl <= '0;
      s3_ctl <= '0;
      s4_ctl <= '0;
      s5_ctl <= '0;
      s6_ctl <= '0;
      win_r  <= '0;
      win_c  <= '0;
      win_up <= '0;
      win_dn <= '0;
    end else begin
      s1_ctl <= '{push: push, emit: emit, bnd: bnd, last: is_last};
      s2_ctl <= s1_ctl;
      s3_ctl <= s2_ctl.push ? s2_ctl : '0;
      s4_ctl <= s3_ctl;
      s5_ctl <= s4_ctl;
      s6_ctl <= s5_ctl;
      if (s2_ctl.push) begin
        win_r  <= s2_m;
        win_c  <= win_r;
        win_up <= $signed(lb2_q);
        win_dn <= s2_b;
      end
    end
  end

  assign hs_ext = $signed({1'b0, h_squared});

  always_ff @(posedge clk) begin
    s1_u   <= u_value;
    s1_ptr <= lb_ptr;

    s2_b <= s1_u;
    s2_m <= $signed(lb1_q);
    s2_f <= $signed(fd_q);

    s3_up <= win_up;
    s3_dn <= win_dn;
    s3_lf <= win_c;
    s3_ct <= win_r;
    s3_rt <= s2_m;
    s3_f  <= s2_f;

    s4_sum  <= 34'(s3_up) + 34'(s3_dn) + 34'(s3_lf) + 34'(s3_rt);
    s4_prod <= hs_ext * s3_f;
    s4_ct   <= s3_ct;

    s5_nv  <= s4_ctl.bnd ? s4_ct : nv_sat;
    s5_old <= s4_ct;

    s6_nv   <= s5_nv;
    s6_diff <= s5_ctl.bnd ? '0 : d_sat;
  end

  always_comb begin
    v_rnd = (42'(s4_sum) <<< 2) - 42'($signed(s4_prod[63:24])) + 42'sd8;
    r_sh  = v_rnd >>> 4;
    if (!r_sh[41] && (|r_sh[40:31])) begin
      nv_sat = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (r_sh[41] && !(&r_sh[40:31])) begin
      nv_sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      nv_sat = r_sh[DATA_W-1:0];
    end
  end

  always_comb begin
    d_raw = 33'(s5_nv) - 33'(s5_old);
    d_abs = d_raw[32] ? 33'(-d_raw) : 33'(d_raw);
    d_sat = (|d_abs[32:31]) ? DIFF_MAX : d_abs[DIFF_W-1:0];
  end

  assign max_next  = (s6_diff > running_max) ? s6_diff : running_max;
  assign fifo_push = s6_ctl.emit;
  assign res_in    = '{new_value: s6_nv,
                       max_diff:  max_next,
                       converged: s6_ctl.last && (max_next < tolerance),
                       last:      s6_ctl.last};

  always_ff @(posedge clk) begin
    if (rst) begin
      running_max <= '0;
    end else if (fifo_push) begin
      running_max <= s6_ctl.last ? '0 : max_next;
    end
  end

  assign out_valid = (fifo_fill != '0);
  assign pop       = out_valid && !out_stall;
  assign in_stall  = (credit >= (FIFO_AW+1)'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (fifo_push) begin
      fifo[fifo_wr] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_wr   <= '0;
      fifo_rd   <= '0;
      fifo_fill <= '0;
      credit    <= '0;
    end else begin
      if (fifo_push) begin
        fifo_wr <= fifo_wr + FIFO_AW'(1);
      end
      if (pop) begin
        fifo_rd <= fifo_rd + FIFO_AW'(1);
      end
      fifo_fill <= fifo_fill + (FIFO_AW+1)'(fifo_push) - (FIFO_AW+1)'(pop);
      credit    <= credit + (FIFO_AW+1)'(emit) - (FIFO_AW+1)'(pop);
    end
  end

  assign new_value = fifo[fifo_rd].new_value;
  assign max_diff  = fifo[fifo_rd].max_diff;
  assign converged = fifo[fifo_rd].converged;
  assign last      = fifo[fifo_rd].last;

endmodule

[hdl/jps_checker.sv]
// Port-level checker for the Jacobi stencil sweep block, bound to its top level.
// Depends on jps_pkg and on jacobi_poisson_stencil_sweep_top.
module jps_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [jps_pkg::DATA_W-1:0] new_value,
  input logic [jps_pkg::DIFF_W-1:0]        max_diff,
  input logic                             converged,
  input logic                             last
);
  import jps_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Output queue not empty after reset.");

  a_conv_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && converged |-> last)
    else $error("Convergence flag on a result that is not the last one.");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("Stalled result was withdrawn.");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(new_value) && $stable(max_diff) &&
                               $stable(converged) && $stable(last))
    else $error("Stalled result changed.");

endmodule

bind jacobi_poisson_stencil_sweep_top jps_checker u_jps_checker (.*);
